@@ rtl/ipa_pkg.sv @@
`timescale 1ns / 1ps

package ipa_pkg;

  // table geometry and datapath widths
  localparam int TABLE_SIZE    = 4096;
  localparam int IDX_W         = $clog2(TABLE_SIZE);
  localparam int QUARTER       = TABLE_SIZE / 4;
  localparam int HALF          = TABLE_SIZE / 2;
  localparam int ROM_DEPTH     = HALF + 1;
  localparam int ROM_AW        = $clog2(ROM_DEPTH);
  localparam int FRACTION_BITS = 8;
  localparam int SAMPLE_WIDTH  = 16;
  localparam int SUM_WIDTH     = 48;
  localparam int PHASE_FRAC    = 20;
  localparam int AMP_W         = 24;
  localparam int PHASE_W       = 32;
  localparam int DIFF_W        = SAMPLE_WIDTH + 1;
  localparam int MUL_A_W       = AMP_W + 1;
  localparam int PROD_W        = MUL_A_W + DIFF_W;
  localparam int INTERP_W      = SAMPLE_WIDTH + 2;
  localparam int CONTRIB_W     = AMP_W + 1;

  localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

  // angle constants in Q30
  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;
  localparam logic [63:0] HALF_Q30 = 64'd536870912;
  localparam logic [63:0] SAMPLE_LIMIT = 64'((64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1);

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef sample_t [ROM_DEPTH-1:0] rom_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_COS_A,
    ST_RD_COS_B,
    ST_RD_SIN_A,
    ST_RD_SIN_B,
    ST_SIN_DIFF,
    ST_MUL_RE,
    ST_ADD_RE,
    ST_ADD_IM
  } state_e;

  // one cosine sample for table position m in [0, TABLE_SIZE/2]
  function automatic sample_t cos_sample(input int m);
    logic [63:0] theta;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] mag;
    logic [63:0] r;
    logic signed [63:0] sum;
    logic neg;
    neg   = 1'b0;
    theta = (64'd2 * PI_Q30 * 64'(m) + 64'(TABLE_SIZE / 2)) / TABLE_SIZE;
    if (theta > PI_Q30 / 2) begin
      theta = (PI_Q30 > theta) ? PI_Q30 - theta : 64'd0;
      neg   = 1'b1;
    end
    // constant term plus ten more taylor terms in Q30
    x2   = (theta * theta) >> 30;
    term = ONE_Q30;
    sum  = $signed(ONE_Q30);
    term = ((term * x2) >> 30) / 64'd2;   sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd12;  sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd30;  sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd56;  sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd90;  sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd132; sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd182; sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd240; sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd306; sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd380; sum = sum + $signed(term);
    if (sum < 0) begin
      sum = -sum;
      neg = ~neg;
    end
    mag = $unsigned(sum);
    r   = ((mag << (SAMPLE_WIDTH - 1)) + HALF_Q30) >> 30;
    if (r > SAMPLE_LIMIT) begin
      r = SAMPLE_LIMIT;
    end
    return neg ? sample_t'(-r) : sample_t'(r);
  endfunction

  // half-wave table, built in blocks of 64 entries
  function automatic rom_t build_rom();
    rom_t rom;
    int   m;
    rom = '0;
    for (int blk = 0; blk < (ROM_DEPTH + 63) / 64; blk++) begin
      for (int j = 0; j < 64; j++) begin
        m = blk * 64 + j;
        if (m < ROM_DEPTH) begin
          rom[m] = cos_sample(m);
        end
      end
    end
    return rom;
  endfunction

  localparam rom_t COS_ROM = build_rom();

endpackage

@@ rtl/interpolated_phasor_accumulator.sv @@
`timescale 1ns / 1ps
// result: registered when the final add step ends; that step stalls while output is busy
// sequencing: items are taken only while idle; the single rom read port and the single
//   shared multiplier are each used four times per item under an 8-step sequencer
// reset: rst_ni asynchronous active low, clears the sequencer, both sums and output valid;
//   the cosine rom is constant and needs no initialization

module interpolated_phasor_accumulator (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       in_valid_i,
  output logic                                       in_ready_o,
  input  logic                                       start_new_i,
  input  logic signed [ipa_pkg::AMP_W-1:0]           amplitude_i,
  input  logic signed [ipa_pkg::PHASE_W-1:0]         phase_turns_i,
  output logic                                       out_valid_o,
  input  logic                                       out_ready_i,
  output logic signed [ipa_pkg::SUM_WIDTH-1:0]       real_total_o,
  output logic signed [ipa_pkg::SUM_WIDTH-1:0]       imag_total_o,
  output logic                                       saturated_o
);

  localparam int FB = ipa_pkg::FRACTION_BITS;
  localparam int SW = ipa_pkg::SAMPLE_WIDTH;

  ipa_pkg::state_e state_q, state_d;

  logic                                  accept;
  logic                                  out_free;
  logic                                  prod_en;
  logic                                  use_amp;

  logic signed [ipa_pkg::AMP_W-1:0]      amp_q;
  logic                                  start_q;
  logic [FB-1:0]                         f_q;
  logic [ipa_pkg::IDX_W-1:0]             k_q;
  logic                                  neg_q;

  logic [ipa_pkg::PHASE_FRAC-1:0]        mag_lo;
  logic [ipa_pkg::IDX_W-1:0]             sin0_idx, sin1_idx, cos1_idx, rd_idx;
  logic [ipa_pkg::IDX_W:0]               mirror_idx;
  logic [ipa_pkg::ROM_AW-1:0]            rom_addr;

  ipa_pkg::sample_t                      rom_q, a_q, v_q;
  logic signed [ipa_pkg::DIFF_W-1:0]     diff;
  logic signed [ipa_pkg::MUL_A_W-1:0]    mul_a;
  logic signed [ipa_pkg::DIFF_W-1:0]     mul_b;
  logic signed [ipa_pkg::PROD_W-1:0]     prod_d, prod_q;
  logic signed [ipa_pkg::INTERP_W-1:0]   interp;
  logic signed [ipa_pkg::CONTRIB_W-1:0]  contrib;

  logic signed [ipa_pkg::SUM_WIDTH-1:0]  real_q, imag_q;
  logic signed [ipa_pkg::SUM_WIDTH-1:0]  sum_base, sum_res;
  logic                                  sum_clip;
  logic                                  clip_q;
  logic                                  out_valid_q;

  // saturating add of one contribution to a sum
  function automatic logic [ipa_pkg::SUM_WIDTH:0] sat_add(
    input logic signed [ipa_pkg::SUM_WIDTH-1:0] base,
    input logic signed [ipa_pkg::CONTRIB_W-1:0] add
  );
    logic signed [ipa_pkg::SUM_WIDTH:0] wide;
    wide = {base[ipa_pkg::SUM_WIDTH-1], base} + (ipa_pkg::SUM_WIDTH+1)'(add);
    if (wide[ipa_pkg::SUM_WIDTH] != wide[ipa_pkg::SUM_WIDTH-1]) begin
      return wide[ipa_pkg::SUM_WIDTH] ? {1'b1, ipa_pkg::SUM_MIN} : {1'b1, ipa_pkg::SUM_MAX};
    end
    return {1'b0, wide[ipa_pkg::SUM_WIDTH-1:0]};
  endfunction

  assign in_ready_o  = (state_q == ipa_pkg::ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  // phase magnitude, low bits only: index and fraction live below the turn bit
  assign mag_lo = phase_turns_i[ipa_pkg::PHASE_W-1] ?
                  (ipa_pkg::PHASE_FRAC)'(-phase_turns_i[ipa_pkg::PHASE_FRAC-1:0]) :
                  phase_turns_i[ipa_pkg::PHASE_FRAC-1:0];

  // table indices modulo the table size
  assign cos1_idx = k_q + ipa_pkg::IDX_W'(1);
  assign sin0_idx = neg_q ? ipa_pkg::IDX_W'(ipa_pkg::QUARTER) + k_q
                          : ipa_pkg::IDX_W'(ipa_pkg::QUARTER) - k_q;
  assign sin1_idx = neg_q ? sin0_idx + ipa_pkg::IDX_W'(1) : sin0_idx - ipa_pkg::IDX_W'(1);

  always_comb begin
    case (state_q)
      ipa_pkg::ST_RD_COS_B: rd_idx = cos1_idx;
      ipa_pkg::ST_RD_SIN_A: rd_idx = sin0_idx;
      ipa_pkg::ST_RD_SIN_B: rd_idx = sin1_idx;
      default:              rd_idx = k_q;
    endcase
  end

  // fold into the half-wave rom by even symmetry
  assign mirror_idx = (ipa_pkg::IDX_W+1)'(ipa_pkg::TABLE_SIZE) - {1'b0, rd_idx};
  assign rom_addr   = ({1'b0, rd_idx} > (ipa_pkg::IDX_W+1)'(ipa_pkg::HALF)) ?
                      mirror_idx[ipa_pkg::ROM_AW-1:0] : rd_idx[ipa_pkg::ROM_AW-1:0];

  // shared multiplier: interpolation step or amplitude scaling
  assign diff    = {rom_q[SW-1], rom_q} - {a_q[SW-1], a_q};
  assign use_amp = (state_q == ipa_pkg::ST_MUL_RE) || (state_q == ipa_pkg::ST_ADD_RE);
  assign mul_a   = use_amp ? {amp_q[ipa_pkg::AMP_W-1], amp_q}
                           : $signed({{(ipa_pkg::MUL_A_W-FB){1'b0}}, f_q});
  assign mul_b   = use_amp ? {v_q[SW-1], v_q} : diff;
  assign prod_d  = mul_a * mul_b;
  assign prod_en = (state_q == ipa_pkg::ST_RD_SIN_A) || (state_q == ipa_pkg::ST_SIN_DIFF)
                   || use_amp;

  // interpolated sample and scaled contribution
  assign interp  = {a_q[SW-1], a_q[SW-1], a_q} + prod_q[FB+ipa_pkg::INTERP_W-1:FB];
  assign contrib = prod_q[ipa_pkg::CONTRIB_W+SW-2:SW-1];

  // saturating accumulate for whichever sum is due, starting from zero on a new start
  always_comb begin
    if (state_q == ipa_pkg::ST_ADD_IM) begin
      sum_base = start_q ? '0 : imag_q;
    end else begin
      sum_base = start_q ? '0 : real_q;
    end
    {sum_clip, sum_res} = sat_add(sum_base, contrib);
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ipa_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ipa_pkg::ST_IDLE:     if (accept) state_d = ipa_pkg::ST_RD_COS_A;
      ipa_pkg::ST_RD_COS_A: state_d = ipa_pkg::ST_RD_COS_B;
      ipa_pkg::ST_RD_COS_B: state_d = ipa_pkg::ST_RD_SIN_A;
      ipa_pkg::ST_RD_SIN_A: state_d = ipa_pkg::ST_RD_SIN_B;
      ipa_pkg::ST_RD_SIN_B: state_d = ipa_pkg::ST_SIN_DIFF;
      ipa_pkg::ST_SIN_DIFF: state_d = ipa_pkg::ST_MUL_RE;
      ipa_pkg::ST_MUL_RE:   state_d = ipa_pkg::ST_ADD_RE;
      ipa_pkg::ST_ADD_RE:   state_d = ipa_pkg::ST_ADD_IM;
      ipa_pkg::ST_ADD_IM:   if (out_free) state_d = ipa_pkg::ST_IDLE;
      default:              state_d = ipa_pkg::ST_IDLE;
    endcase
  end

  // sums and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      real_q      <= '0;
      imag_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == ipa_pkg::ST_ADD_RE) begin
        real_q <= sum_res;
      end
      if (state_q == ipa_pkg::ST_ADD_IM && out_free) begin
        imag_q      <= sum_res;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk_i) begin
    rom_q <= ipa_pkg::COS_ROM[rom_addr];
    if (accept) begin
      amp_q   <= amplitude_i;
      start_q <= start_new_i;
      neg_q   <= phase_turns_i[ipa_pkg::PHASE_W-1];
      k_q     <= mag_lo[ipa_pkg::PHASE_FRAC-1 -: ipa_pkg::IDX_W];
      f_q     <= mag_lo[ipa_pkg::PHASE_FRAC-ipa_pkg::IDX_W-1 -: FB];
    end
    if (prod_en) begin
      prod_q <= prod_d;
    end
    if (state_q == ipa_pkg::ST_RD_COS_B || state_q == ipa_pkg::ST_RD_SIN_B) begin
      a_q <= rom_q;
    end
    if (state_q == ipa_pkg::ST_RD_SIN_B || state_q == ipa_pkg::ST_MUL_RE) begin
      v_q <= interp[SW-1:0];
    end
    if (state_q == ipa_pkg::ST_ADD_RE) begin
      clip_q <= sum_clip;
    end
    if (state_q == ipa_pkg::ST_ADD_IM && out_free) begin
      real_total_o <= real_q;
      imag_total_o <= sum_res;
      saturated_o  <= clip_q | sum_clip;
    end
  end

  // an accepted transaction reaches the final add step with no stall along the way
  a_seq_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##8 (state_q == ipa_pkg::ST_ADD_IM))
    else $error("sequencer length mismatch");

  // a new result only comes out of the final add step
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == ipa_pkg::ST_ADD_IM))
    else $error("result raised outside final step");

  // a clipped result leaves at least one sum at a limit
  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |->
      (real_total_o == ipa_pkg::SUM_MAX || real_total_o == ipa_pkg::SUM_MIN ||
       imag_total_o == ipa_pkg::SUM_MAX || imag_total_o == ipa_pkg::SUM_MIN))
    else $error("saturation flag without clamped sum");

  // no new transaction is taken while one is in flight
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("input taken while busy");

endmodule
